// File: hdl/psws_pkg.sv
`default_nettype none

package psws_pkg;

    // Configuration register indexes
    localparam logic CFG_FRAME_BASE = 1'b0;
    localparam logic CFG_ROW_STRIDE = 1'b1;

    localparam logic [15:0] FRAME_BASE_RESET = 16'd0;
    localparam logic [7:0]  ROW_STRIDE_RESET = 8'd80;
    localparam logic [3:0]  ALL_PLANES       = 4'd15;

    // Line fill request
    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [10:0] span_width;
        logic [7:0]  fill_color;
    } psws_req_t;

    // Write span result
    typedef struct packed {
        logic [15:0] write_address;
        logic [3:0]  plane_mask;
        logic [9:0]  byte_count;
        logic [7:0]  span_color;
        logic        last_span;
    } psws_span_t;

    // Classified line, as queued between front and back
    typedef struct packed {
        logic [15:0] addr;
        logic [9:0]  mid;
        logic [3:0]  lmask;
        logic [3:0]  rmask;
        logic        single;
        logic [7:0]  color;
    } psws_desc_t;

    // Planes enabled in the leftmost byte, by pixel position within the byte
    function automatic logic [3:0] left_edge_mask(input logic [1:0] pos);
        logic [3:0] m;
        case (pos)
            2'd0:    m = 4'd15;
            2'd1:    m = 4'd14;
            2'd2:    m = 4'd12;
            2'd3:    m = 4'd8;
            default: m = 4'd15;
        endcase
        return m;
    endfunction

    // Planes enabled in the rightmost byte, by pixel position within the byte
    function automatic logic [3:0] right_edge_mask(input logic [1:0] pos);
        logic [3:0] m;
        case (pos)
            2'd0:    m = 4'd1;
            2'd1:    m = 4'd3;
            2'd2:    m = 4'd7;
            2'd3:    m = 4'd15;
            default: m = 4'd15;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hdl/psws_front.sv
`default_nettype none

module psws_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire                   cfg_index,
    input  wire  [15:0]           cfg_data,
    input  wire                   req_valid,
    output logic                  req_ready,
    input  psws_pkg::psws_req_t   req,
    output logic                  push_valid,
    input  wire                   push_ready,
    output psws_pkg::psws_desc_t  push_desc
);
    import psws_pkg::*;

    logic [15:0] frame_base_reg;
    logic [7:0]  row_stride_reg;
    logic [16:0] row_offset;
    logic [7:0]  first_col;
    logic [11:0] end_pixel;
    logic [9:0]  last_col;

    // Take register writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= FRAME_BASE_RESET;
            row_stride_reg <= ROW_STRIDE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_FRAME_BASE)
                frame_base_reg <= cfg_data;
            else
                row_stride_reg <= cfg_data[7:0];
        end
    end

    // Locate the byte columns of both line ends
    always_comb
    begin
        first_col  = req.pixel_x[9:2];
        end_pixel  = {2'b00, req.pixel_x} + {1'b0, req.span_width} - 12'd1;
        last_col   = end_pixel[11:2];
        row_offset = 17'(req.pixel_y) * 17'(row_stride_reg);
    end

    // Build the line descriptor
    always_comb
    begin
        push_desc.addr   = frame_base_reg + row_offset[15:0] + {8'b0, first_col};
        push_desc.single = (last_col == {2'b00, first_col});
        push_desc.mid    = last_col - {2'b00, first_col} - 10'd1;
        push_desc.lmask  = left_edge_mask(req.pixel_x[1:0]);
        push_desc.rmask  = right_edge_mask(end_pixel[1:0]);
        push_desc.color  = req.fill_color;
    end

    // Drop zero-width lines; queue everything else
    assign push_valid = req_valid && (req.span_width != 11'd0);
    assign req_ready  = push_ready;

endmodule

`default_nettype wire

// File: hdl/psws_queue.sv
`default_nettype none

module psws_queue #(
    parameter int DEPTH = 2
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push_valid,
    output logic                  push_ready,
    input  psws_pkg::psws_desc_t  push_desc,
    output logic                  head_valid,
    output psws_pkg::psws_desc_t  head_desc,
    input  wire                   pop
);
    import psws_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    psws_desc_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign push       = push_valid && push_ready;
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: hdl/psws_back.sv
`default_nettype none

module psws_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   head_valid,
    input  psws_pkg::psws_desc_t  head_desc,
    output logic                  pop,
    output logic                  span_valid,
    input  wire                   span_ready,
    output psws_pkg::psws_span_t  span
);
    import psws_pkg::*;

    localparam logic [1:0] PH_LEFT  = 2'd0;
    localparam logic [1:0] PH_MID   = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        span_valid_reg;
    logic        span_valid_next;
    psws_span_t  span_reg;
    psws_span_t  cur_span;
    logic        load;

    // Emit a span whenever the output register is free or being drained
    assign load = head_valid && (!span_valid_reg || span_ready);

    // Form the span for the current phase of the head request
    always_comb
    begin
        cur_span.write_address = head_desc.addr;
        cur_span.plane_mask    = head_desc.lmask;
        cur_span.byte_count    = 10'd1;
        cur_span.span_color    = head_desc.color;
        cur_span.last_span     = 1'b0;
        phase_next             = phase_reg;
        case (phase_reg)
            PH_LEFT:
            begin
                if (head_desc.single)
                begin
                    cur_span.plane_mask = head_desc.lmask & head_desc.rmask;
                    cur_span.last_span  = 1'b1;
                end
                else if (head_desc.mid != 10'd0)
                    phase_next = PH_MID;
                else
                    phase_next = PH_RIGHT;
            end
            PH_MID:
            begin
                cur_span.write_address = head_desc.addr + 16'd1;
                cur_span.plane_mask    = ALL_PLANES;
                cur_span.byte_count    = head_desc.mid;
                phase_next             = PH_RIGHT;
            end
            PH_RIGHT:
            begin
                cur_span.write_address = head_desc.addr + {6'b0, head_desc.mid} + 16'd1;
                cur_span.plane_mask    = head_desc.rmask;
                cur_span.last_span     = 1'b1;
            end
            default:
            begin
                cur_span.last_span = 1'b1;
            end
        endcase
        if (cur_span.last_span)
            phase_next = PH_LEFT;
    end

    assign pop = load && cur_span.last_span;

    always_comb
    begin
        if (load)
            span_valid_next = 1'b1;
        else if (span_ready)
            span_valid_next = 1'b0;
        else
            span_valid_next = span_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEFT;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            span_valid_reg <= span_valid_next;
            if (load)
                phase_reg <= phase_next;
        end
    end

    // Hold the output span until taken
    always_ff @(posedge clk)
    begin
        if (load)
            span_reg <= cur_span;
    end

    assign span_valid = span_valid_reg;
    assign span       = span_reg;

    a_mid_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MID) |-> (head_valid && !head_desc.single && head_desc.mid != 10'd0))
        else $error("middle phase without a middle run");

    a_right_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RIGHT) |-> (head_valid && !head_desc.single))
        else $error("right edge phase on a single-byte line");

endmodule

`default_nettype wire

// File: hdl/planar_span_write_splitter.sv
`default_nettype none

// Splits horizontal line fill requests for a four-plane frame buffer into
// write spans (address, plane mask, byte count, color). Each line gives one
// span when it fits in one byte column, otherwise a left edge byte, a
// full-mask middle run when non-empty, and a right edge byte; zero-width
// lines give none. The front takes one request per cycle while the queue
// has room, computes the start address and edge masks, and queues the
// result; the back sends out one span per cycle from a registered output
// while that output is free or being taken, and releases a request from
// the queue with its last span. The first span passes through the queue
// entry and then the output register before it is presented. The user
// must write registers frame_base (index 0) and row_stride (index 1) only
// while idle; the block itself does not enforce it.
module planar_span_write_splitter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire                   cfg_index,
    input  wire  [15:0]           cfg_data,
    input  wire                   req_valid,
    output logic                  req_ready,
    input  psws_pkg::psws_req_t   req,
    output logic                  span_valid,
    input  wire                   span_ready,
    output psws_pkg::psws_span_t  span
);
    import psws_pkg::*;

    logic        push_valid;
    logic        push_ready;
    psws_desc_t  push_desc;
    logic        head_valid;
    psws_desc_t  head_desc;
    logic        pop;

    psws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    psws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop)
    );

    psws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span       (span)
    );

endmodule

`default_nettype wire
